[rtl/cft_pkg.sv]
// ----------------------------------------------------------------------------
// cft_pkg
// shared types and constants of the csv field tokenizer
// ----------------------------------------------------------------------------
package cft_pkg;

  // result kinds
  typedef enum logic [2:0] {
    KIND_BYTE = 3'd0,
    KIND_CELL = 3'd1,
    KIND_ROW  = 3'd2,
    KIND_DONE = 3'd3,
    KIND_ERR  = 3'd4
  } kind_e;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // result slots of one item, in delivery order
  localparam int unsigned SLOT_CR    = 0;
  localparam int unsigned SLOT_BYTE  = 1;
  localparam int unsigned SLOT_CELLA = 2;
  localparam int unsigned SLOT_CELLB = 3;
  localparam int unsigned SLOT_ROW   = 4;
  localparam int unsigned SLOT_TAIL  = 5;
  localparam int unsigned NumSlots   = 6;

  typedef struct packed {
    logic inside_quotes;
    logic quote_pending;
    logic held_return;
    logic cell_started;
    logic row_started;
    logic row_nonblank;
  } cft_state_t;

  // pending results of one item
  typedef struct packed {
    logic [NumSlots-1:0] mask;
    logic [7:0]          text_byte;
    logic                row_flag;
    logic                tail_err;
  } cft_group_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

[rtl/cft_step.sv]
// ----------------------------------------------------------------------------
// cft_step
// decodes one text byte against the tokenizer state into the next state
// and the set of results the byte causes
// ----------------------------------------------------------------------------
module cft_step (
  input  logic [7:0]          byte_i,
  input  logic                final_i,
  input  cft_pkg::cft_state_t state_i,
  output cft_pkg::cft_state_t state_o,
  output cft_pkg::cft_group_t group_o
);
  import cft_pkg::*;

  cft_state_t st;
  cft_group_t g;
  logic       take;
  logic       used;
  logic       do_cell;
  logic       do_row;

  always_comb begin
    st      = state_i;
    g       = '0;
    g.text_byte = byte_i;
    take    = 1'b0;
    used    = 1'b0;
    do_cell = 1'b0;
    do_row  = 1'b0;

    // a quote seen inside quotes is either doubled or closes the quotes
    if (st.inside_quotes && st.quote_pending) begin
      st.quote_pending = 1'b0;
      if (byte_i == CH_QUOTE) begin
        take = 1'b1;
        used = 1'b1;
      end else begin
        st.inside_quotes = 1'b0;
      end
    end

    if (!used) begin
      if (st.inside_quotes) begin
        if (byte_i == CH_QUOTE) begin
          st.quote_pending = 1'b1;
        end else begin
          take = 1'b1;
        end
      end else if (byte_i == CH_QUOTE) begin
        st.inside_quotes = 1'b1;
      end else if (byte_i == CH_COMMA) begin
        do_cell = 1'b1;
      end else if (byte_i == CH_NL) begin
        do_cell = 1'b1;
        do_row  = 1'b1;
      end else begin
        take = 1'b1;
      end
    end

    if (take) begin
      g.mask[SLOT_CR] = st.held_return;
      if (byte_i == CH_CR) begin
        st.held_return = 1'b1;
      end else begin
        st.held_return = 1'b0;
        g.mask[SLOT_BYTE] = 1'b1;
        if (!is_space(byte_i)) begin
          st.row_nonblank = 1'b1;
        end
      end
      st.cell_started = 1'b1;
    end

    if (do_cell) begin
      st.held_return = 1'b0;
      g.mask[SLOT_CELLA] = 1'b1;
      st.cell_started = 1'b0;
      st.row_started  = 1'b1;
    end

    if (do_row) begin
      g.mask[SLOT_ROW] = 1'b1;
      g.row_flag       = st.row_nonblank;
      st.row_started   = 1'b0;
      st.row_nonblank  = 1'b0;
    end

    if (final_i) begin
      g.mask[SLOT_TAIL] = 1'b1;
      if (st.inside_quotes && !st.quote_pending) begin
        g.tail_err = 1'b1;
      end else if (st.cell_started || st.row_started) begin
        g.mask[SLOT_CELLB] = 1'b1;
        g.mask[SLOT_ROW]   = 1'b1;
        g.row_flag         = st.row_nonblank;
      end
      st = '0;
    end
  end

  assign state_o = st;
  assign group_o = g;

endmodule

[rtl/csv_field_tokenizer.sv]
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// streaming csv tokenizer: text bytes in, cell bytes and cell/row markers out
// ----------------------------------------------------------------------------
// Input channel s_axis: one byte of csv text per item in tdata[7:0], tlast
// high on the byte that ends the text. Output channel m_axis: one result per
// item, tuser the result kind (byte, end of cell, end of row, done, quote
// error), tdata the cell byte and the row content flag, tlast high on the
// last result caused by one input byte.
// Pipeline: input register, decode into a result group register, output
// register. A byte is taken every cycle as long as each byte causes at
// most one result and m_axis_tready stays high; a byte causing more than
// one result holds the group register until its last result is loaded into
// the output register (at most five, a byte that also ends the text), and
// the group register absorbs one such burst while the output register waits.
// Reset clears the quote, cell and row state and empties all stages. When
// m_axis_tready is low the output register holds, the group register fills,
// then the input register, and s_axis_tready drops. After the final byte
// the state returns to its reset value for the next text. On a quote error
// the downstream side drops what it took for that text.
// ----------------------------------------------------------------------------
module csv_field_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] cell_byte, [8] row_has_content
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast    // last_of_run
);
  import cft_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_final_q;

  cft_state_t state_q, state_d;
  cft_group_t grp_q, grp_d;

  logic                out_valid_q;
  logic [2:0]          out_kind_q;
  logic [7:0]          out_byte_q;
  logic                out_flag_q;
  logic                out_last_q;

  logic [NumSlots-1:0] pick;
  logic [NumSlots-1:0] rest;
  logic                out_load;
  logic                grp_free;
  logic                move;
  logic [2:0]          sel_kind;
  logic [7:0]          sel_byte;
  logic                sel_flag;

  cft_step u_step (
    .byte_i  (in_byte_q),
    .final_i (in_final_q),
    .state_i (state_q),
    .state_o (state_d),
    .group_o (grp_d)
  );

  // lowest pending slot goes out next
  assign pick     = grp_q.mask & (~grp_q.mask + NumSlots'(1));
  assign rest     = grp_q.mask & ~pick;
  assign out_load = (grp_q.mask != '0) && (!out_valid_q || m_axis_tready);
  assign grp_free = (grp_q.mask == '0) || (out_load && (rest == '0));
  assign move     = in_valid_q && grp_free;

  assign s_axis_tready = !in_valid_q || move;

  always_comb begin
    sel_kind = KIND_BYTE;
    sel_byte = 8'h00;
    sel_flag = 1'b0;
    if (pick[SLOT_CR]) begin
      sel_byte = CH_CR;
    end else if (pick[SLOT_BYTE]) begin
      sel_byte = grp_q.text_byte;
    end else if (pick[SLOT_CELLA] || pick[SLOT_CELLB]) begin
      sel_kind = KIND_CELL;
    end else if (pick[SLOT_ROW]) begin
      sel_kind = KIND_ROW;
      sel_flag = grp_q.row_flag;
    end else if (grp_q.tail_err) begin
      sel_kind = KIND_ERR;
    end else begin
      sel_kind = KIND_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_final_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (move) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
    end else if (move) begin
      grp_q <= grp_d;
    end else if (out_load) begin
      grp_q.mask <= rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= sel_kind;
      out_byte_q <= sel_byte;
      out_flag_q <= sel_flag;
      out_last_q <= (rest == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {7'd0, out_flag_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  // done and error always close the run of one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_DONE || m_axis_tuser == KIND_ERR)
      |-> m_axis_tlast)
    else $error("done or error not marked last");

  // marker results carry no cell byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_BYTE) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("marker result with nonzero cell byte");

  // a byte never causes more than five results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(grp_q.mask) <= 5)
    else $error("result group overfull");

  // the state is back at reset once a final byte has been decoded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && in_final_q |=> (state_q == '0))
    else $error("state not cleared after final byte");

  // a byte waiting in the input register for decode is not lost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !move |=> in_valid_q && $stable(in_byte_q))
    else $error("input item dropped before decode");
`endif

endmodule

[test/csv_field_tokenizer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer_test
// drives csv text into the tokenizer byte by byte, with random gaps on the
// input and random stalls on the output, and checks every result against
// a cell/row tokenizer model kept alongside
// ----------------------------------------------------------------------------
module csv_field_tokenizer_test;
  import cft_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 400;

  typedef struct {
    logic [7:0] text;
    logic       fin;
  } text_item_t;

  typedef struct {
    kind_e      kind;
    logic [7:0] byte_val;
    logic       has_content;
    logic       last;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] text_byte
  logic        s_axis_tlast = 1'b0; // final_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [7:0] cell_byte, [8] row_has_content
  logic [2:0]  m_axis_tuser;        // [2:0] kind
  logic        m_axis_tlast;        // last_of_run

  text_item_t  text_q[$];
  token_t      pending_tokens[$];
  cft_state_t  tok = '0;
  text_item_t  cur_item;
  token_t      want;
  int          src_gap = 0;
  int          src_calm = 0;
  int          sink_wait = 0;
  int          sink_calm = 0;
  int          sink_hold = 0;
  bit          hold_done = 1'b0;
  int          n_checked = 0;
  int          errors = 0;
  int unsigned cycles = 0;

  csv_field_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic void emit(input kind_e k, input logic [7:0] b, input logic f);
    token_t t;
    t.kind        = k;
    t.byte_val    = b;
    t.has_content = f;
    t.last        = 1'b0;
    pending_tokens = {pending_tokens, t};
  endfunction

  function automatic logic blank_byte(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic void add_to_cell(input logic [7:0] b);
    // a held carriage return only survives if the cell goes on
    if (tok.held_return) emit(KIND_BYTE, CH_CR, 1'b0);
    if (b == CH_CR) begin
      tok.held_return = 1'b1;
    end else begin
      tok.held_return = 1'b0;
      emit(KIND_BYTE, b, 1'b0);
      if (!blank_byte(b)) tok.row_nonblank = 1'b1;
    end
    tok.cell_started = 1'b1;
  endfunction

  function automatic void close_cell();
    tok.held_return  = 1'b0;
    emit(KIND_CELL, 8'h00, 1'b0);
    tok.cell_started = 1'b0;
    tok.row_started  = 1'b1;
  endfunction

  function automatic void close_row();
    close_cell();
    emit(KIND_ROW, 8'h00, tok.row_nonblank);
    tok.cell_started = 1'b0;
    tok.row_started  = 1'b0;
    tok.row_nonblank = 1'b0;
  endfunction

  function automatic void tokenize_byte(input logic [7:0] b, input logic fin);
    int  n_prior;
    bit  used;
    n_prior = pending_tokens.size();
    used    = 1'b0;
    if (tok.inside_quotes && tok.quote_pending) begin
      tok.quote_pending = 1'b0;
      if (b == CH_QUOTE) begin
        add_to_cell(CH_QUOTE);
        used = 1'b1;
      end else begin
        tok.inside_quotes = 1'b0;
      end
    end
    if (!used) begin
      if (tok.inside_quotes) begin
        if (b == CH_QUOTE) tok.quote_pending = 1'b1;
        else add_to_cell(b);
      end else if (b == CH_QUOTE) begin
        tok.inside_quotes = 1'b1;
      end else if (b == CH_COMMA) begin
        close_cell();
      end else if (b == CH_NL) begin
        close_row();
      end else begin
        add_to_cell(b);
      end
    end
    if (fin) begin
      // a quote still pending at the end just closes the quoted text
      if (tok.inside_quotes && !tok.quote_pending) begin
        emit(KIND_ERR, 8'h00, 1'b0);
      end else begin
        if (tok.cell_started || tok.row_started) close_row();
        emit(KIND_DONE, 8'h00, 1'b0);
      end
      tok = '0;
    end
    if (pending_tokens.size() > n_prior) pending_tokens[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_byte(input logic [7:0] b, input logic fin);
    text_item_t it;
    it.text = b;
    it.fin  = fin;
    text_q = {text_q, it};
  endtask

  task automatic add_str(input string s, input logic fin_last);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], fin_last && (i == s.len() - 1));
  endtask

  task automatic gen_cell(ref logic [7:0] bq[$]);
    int         len;
    int         pick;
    logic [7:0] b;
    len = $urandom_range(0, 4);
    if ($urandom_range(0, 9) < 5) begin
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 7);
        case (pick)
          4: b = CH_SPACE;
          5: b = CH_TAB;
          6: b = CH_CR;
          7: b = 8'($urandom_range(0, 255));
          default: b = 8'($urandom_range(97, 122));
        endcase
        bq = {bq, b};
      end
    end else begin
      bq = {bq, CH_QUOTE};
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 7);
        case (pick)
          3: b = CH_COMMA;
          4: b = CH_NL;
          5: b = CH_QUOTE;
          6: b = CH_CR;
          7: b = 8'($urandom_range(0, 255));
          default: b = 8'($urandom_range(65, 90));
        endcase
        // quotes inside quoted text go doubled
        if (b == CH_QUOTE) bq = {bq, CH_QUOTE};
        bq = {bq, b};
      end
      // now and then the closing quote is missing
      if ($urandom_range(0, 9) != 0) bq = {bq, CH_QUOTE};
    end
  endtask

  task automatic gen_text();
    logic [7:0] bq[$];
    int         rows;
    int         cols;
    rows = $urandom_range(1, 3);
    for (int r = 0; r < rows; r++) begin
      cols = $urandom_range(1, 4);
      for (int c = 0; c < cols; c++) begin
        if (c > 0) bq = {bq, CH_COMMA};
        gen_cell(bq);
      end
      if ((r < rows - 1) || ($urandom_range(0, 1) == 1)) bq = {bq, CH_NL};
    end
    if (bq.size() == 0) bq = {bq, CH_NL};
    for (int i = 0; i < bq.size(); i++) add_byte(bq[i], i == bq.size() - 1);
  endtask

  task automatic gen_noise();
    int len;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++)
      add_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0) || (i == len - 1));
  endtask

  task automatic fill_text();
    // quoted cell with a doubled quote, then a comma
    add_str("\"a\"\"b\",", 1'b0);
    // returns in a row, one dropped at cell end
    add_byte(CH_CR, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(CH_COMMA, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(CH_NL, 1'b0);
    // blank row
    add_str(" \t", 1'b0);
    add_byte(CH_NL, 1'b0);
    // empty quoted cell alone, quote pending at the end
    add_byte(CH_QUOTE, 1'b0);
    add_byte(CH_QUOTE, 1'b1);
    // unterminated quote
    add_str("x\"z", 1'b1);
    // held return then a byte that ends the text: five results
    add_byte(CH_CR, 1'b0);
    add_byte(8'h77, 1'b1);
    add_byte(CH_NL, 1'b1);
    add_byte(CH_COMMA, 1'b1);
    add_byte(CH_QUOTE, 1'b1);
    while (text_q.size() < 262) begin
      if ($urandom_range(0, 5) == 0) gen_noise();
      else gen_text();
    end
  endtask

  // gap before the next item, with stretches of no gaps at all
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) tokenize_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (text_q.size() > 0) begin
          cur_item = text_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_item.text;
          s_axis_tlast  <= cur_item.fin;
          src_gap = draw_wait(src_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- long stall

  // one long stall so the pipeline backs up into the input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_hold <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && (n_checked >= 40)) begin
      hold_done <= 1'b1;
      sink_hold <= LongHold;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_tokens.size() == 0) begin
          $display("%0t unexpected result: kind %0d byte %02h flag %0b last %0b", $time,
                   m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tlast);
          errors++;
        end else begin
          want = pending_tokens.pop_front();
          if ((m_axis_tuser !== want.kind) || (m_axis_tdata[7:0] !== want.byte_val) ||
              (m_axis_tdata[8] !== want.has_content) || (m_axis_tlast !== want.last)) begin
            $display("%0t mismatch: expected kind %0d byte %02h flag %0b last %0b,",
                     $time, want.kind, want.byte_val, want.has_content, want.last,
                     " got kind %0d byte %02h flag %0b last %0b",
                     m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tlast);
            errors++;
          end
        end
        n_checked++;
        sink_wait = draw_wait(sink_calm);
      end
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    fill_text();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    while ((text_q.size() > 0) || s_axis_tvalid || (pending_tokens.size() > 0)) begin
      @(posedge clk_i);
      #1;
    end
    repeat (30) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
